@@ design/assert_macros.svh @@
// Assertion helper macros shared by the delay line RTL.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFDL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfdl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFDL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfdl assertion failed");

`endif

@@ design/sfdl_pkg.sv @@
// Shared types and constants for the stereo feedback delay line.
// Used by the controller, the datapath and the top level; no dependencies.
package sfdl_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;
    localparam int FRAC_W     = 8;
    localparam int DINT_W     = CFG_DATA_W - FRAC_W;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BALANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WET     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd6;

    localparam int GAIN_W = 17;
    localparam int WET_W  = 19;

    localparam logic [GAIN_W-1:0] BALANCE_RST = 17'd32768;
    localparam logic [GAIN_W-1:0] DRY_RST     = 17'd65536;
    localparam logic [WET_W-1:0]  WET_RST     = 19'd65536;
    localparam logic signed [GAIN_W:0] ONE_Q16 = 18'sd65536;

    typedef struct packed {
        logic clr;
        logic load;
        logic rd_b;
        logic interp;
        logic dly;
        logic mul;
        logic wb;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_busy;
    } t_status;

endpackage

@@ design/sfdl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sfdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/sfdl_ctrl.sv @@
// Sequencing state machine of the delay line: clearing pass, item steps, output handshake.
// Depends on sfdl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfdl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  logic              i_m_ready,
    output logic              o_m_valid,
    output sfdl_pkg::t_cmd    o_cmd,
    input  sfdl_pkg::t_status i_status
);
    import sfdl_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RDB   = 7'b0000100,
        S_INT   = 7'b0001000,
        S_DLY   = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_WB    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   out_free;
    t_cmd   cmd;

    assign out_free  = !r_ovalid || i_m_ready;
    assign o_s_ready = (r_state == S_IDLE) && !i_status.mod_busy;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_valid && !i_status.mod_busy) begin
                    cmd.load = 1'b1;
                    n_state  = S_RDB;
                end
            end
            S_RDB: begin
                cmd.rd_b = 1'b1;
                n_state  = S_INT;
            end
            S_INT: begin
                cmd.interp = 1'b1;
                n_state    = S_DLY;
            end
            S_DLY: begin
                cmd.dly = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_WB;
            end
            S_WB: begin
                if (out_free) begin
                    cmd.wb  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (cmd.wb) begin
            n_ovalid = 1'b1;
        end else if (i_m_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_cmd     = cmd;
    assign o_m_valid = r_ovalid;

    `SFDL_ASSERT_NOW(a_clear_blocks_input, i_clk, i_rst_n, r_state == S_CLEAR, !o_s_ready)
    `SFDL_ASSERT_NEXT(a_wb_delivers, i_clk, i_rst_n, (r_state == S_WB) && out_free,
                      (r_state == S_IDLE) && r_ovalid)

endmodule

@@ design/sfdl_dp.sv @@
// Datapath of the delay line: configuration registers, delay reduction, read index,
// two line memories, interpolation, feedback and output mixing. Depends on sfdl_pkg,
// sfdl_ram and assert_macros.svh.
`include "assert_macros.svh"

module sfdl_dp #(
    parameter int LINE_DEPTH  = 262144,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sfdl_pkg::t_cmd                   i_cmd,
    output sfdl_pkg::t_status                o_status,
    input  logic                             i_cfg_we,
    input  logic [sfdl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sfdl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]    i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]    i_right_in,
    output logic signed [SAMPLE_BITS-1:0]    o_left_out,
    output logic signed [SAMPLE_BITS-1:0]    o_right_out
);
    import sfdl_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int LB   = $clog2(LINE_DEPTH);
    localparam int NLOG = $clog2(LINE_DEPTH + 1) - 1;
    localparam int QB   = (DINT_W > NLOG) ? (DINT_W - NLOG) : 1;
    localparam int QCW  = $clog2(QB + 1);
    localparam int SW   = DINT_W + LB + 1;

    localparam logic [SW-1:0]  DIV_INIT = SW'(LINE_DEPTH) << (QB - 1);
    localparam logic [LB:0]    DEPTH_X  = (LB + 1)'(LINE_DEPTH);
    localparam logic [LB-1:0]  LAST_IDX = LB'(LINE_DEPTH - 1);
    localparam logic [QCW-1:0] QB_CNT   = QCW'(QB);
    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB - 1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB - 1){1'b0}}};

    function automatic logic signed [SB-1:0] f_sat(input logic signed [SB+5:0] v);
        logic signed [SB+5:0] hi;
        logic signed [SB+5:0] lo;
        hi = (SB + 6)'(SMAX);
        lo = (SB + 6)'(SMIN);
        if (v > hi) begin
            return SMAX;
        end else if (v < lo) begin
            return SMIN;
        end
        return v[SB-1:0];
    endfunction

    logic [CFG_DATA_W-1:0] r_delay;
    logic [GAIN_W-1:0]     r_fb, r_bal, r_dry;
    logic [WET_W-1:0]      r_wet;
    logic                  r_pp, r_en;

    logic [DINT_W-1:0] r_rem;
    logic [SW-1:0]     r_div;
    logic [QCW-1:0]    r_mcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= '0;
            r_fb    <= '0;
            r_pp    <= 1'b0;
            r_bal   <= BALANCE_RST;
            r_dry   <= DRY_RST;
            r_wet   <= WET_RST;
            r_en    <= 1'b1;
            r_rem   <= '0;
            r_div   <= DIV_INIT;
            r_mcnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_DELAY:   r_delay <= i_cfg_data;
                    REG_FB:      r_fb    <= i_cfg_data[GAIN_W-1:0];
                    REG_PP:      r_pp    <= i_cfg_data[0];
                    REG_BALANCE: r_bal   <= i_cfg_data[GAIN_W-1:0];
                    REG_DRY:     r_dry   <= i_cfg_data[GAIN_W-1:0];
                    REG_WET:     r_wet   <= i_cfg_data[WET_W-1:0];
                    REG_ENABLE:  r_en    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cfg_we && (i_cfg_idx == REG_DELAY)) begin
                r_rem  <= i_cfg_data[FRAC_W +: DINT_W];
                r_div  <= DIV_INIT;
                r_mcnt <= QB_CNT;
            end else if (r_mcnt != '0) begin
                if (SW'(r_rem) >= r_div) begin
                    r_rem <= DINT_W'(SW'(r_rem) - r_div);
                end
                r_div  <= r_div >> 1;
                r_mcnt <= r_mcnt - 1'b1;
            end
        end
    end

    logic [LB-1:0]     r_w, r_ri;
    logic [FRAC_W-1:0] fr, f_new, r_f;
    logic              carry, r_hit;
    logic [LB-1:0]     dm, ri_new, ri_next, raddr, w_next;
    logic [LB:0]       ri_sum;

    assign fr      = r_delay[FRAC_W-1:0];
    assign carry   = |fr;
    assign f_new   = FRAC_W'(-fr);
    assign dm      = LB'(r_rem);
    assign ri_sum  = {1'b0, r_w} + DEPTH_X - (LB + 1)'(dm) - (LB + 1)'(carry);
    assign ri_new  = (ri_sum >= DEPTH_X) ? LB'(ri_sum - DEPTH_X) : LB'(ri_sum);
    assign ri_next = (r_ri == LAST_IDX) ? '0 : r_ri + 1'b1;
    assign w_next  = (r_w == LAST_IDX) ? '0 : r_w + 1'b1;
    assign raddr   = i_cmd.rd_b ? ri_next : ri_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '0;
        end else if (i_cmd.clr || i_cmd.wb) begin
            r_w <= w_next;
        end
    end

    assign o_status.clr_last = (r_w == LAST_IDX);
    assign o_status.mod_busy = (r_mcnt != '0);

    logic signed [SB-1:0] r_xl, r_xr, r_a_l, r_a_r, r_d_l, r_d_r;
    logic signed [SB+9:0] r_prod_l, r_prod_r;
    logic signed [SB+1:0] r_win_l, r_win_r, r_fbt_l, r_fbt_r;
    logic signed [SB+17:0] r_dry_l, r_dry_r;
    logic signed [SB+19:0] r_wetp_l, r_wetp_r;
    logic signed [SB-1:0] r_out_l, r_out_r;

    logic signed [SB-1:0]  rd_l, rd_r, line_l, line_r, wdata_l, wdata_r;
    logic signed [SB:0]    diff_l, diff_r;
    logic signed [SB+9:0]  prod_l, prod_r;
    logic signed [SB+10:0] isum_l, isum_r;
    logic signed [GAIN_W:0] bal_s, rbal_s;
    logic signed [SB+17:0] pl, pr, dryp_l, dryp_r, fbp_l, fbp_r;
    logic signed [SB+19:0] wetp_l, wetp_r;
    logic signed [SB+1:0]  fsel_l, fsel_r;
    logic signed [SB+2:0]  lsum_l, lsum_r;
    logic signed [SB+20:0] osum_l, osum_r;
    logic                  we;

    assign diff_l = (SB + 1)'(rd_l) - (SB + 1)'(r_a_l);
    assign diff_r = (SB + 1)'(rd_r) - (SB + 1)'(r_a_r);
    assign prod_l = $signed({1'b0, r_f}) * diff_l;
    assign prod_r = $signed({1'b0, r_f}) * diff_r;
    assign isum_l = ((SB + 11)'(r_a_l) <<< FRAC_W) + (SB + 11)'(r_prod_l);
    assign isum_r = ((SB + 11)'(r_a_r) <<< FRAC_W) + (SB + 11)'(r_prod_r);

    assign bal_s  = $signed({1'b0, r_bal});
    assign rbal_s = ONE_Q16 - bal_s;
    assign pl     = r_xl * bal_s;
    assign pr     = r_xr * rbal_s;
    assign dryp_l = r_xl * $signed({1'b0, r_dry});
    assign dryp_r = r_xr * $signed({1'b0, r_dry});

    assign fbp_l  = r_d_l * $signed({1'b0, r_fb});
    assign fbp_r  = r_d_r * $signed({1'b0, r_fb});
    assign wetp_l = r_d_l * $signed({1'b0, r_wet});
    assign wetp_r = r_d_r * $signed({1'b0, r_wet});

    assign fsel_l = r_pp ? r_fbt_r : r_fbt_l;
    assign fsel_r = r_pp ? r_fbt_l : r_fbt_r;
    assign lsum_l = (SB + 3)'(r_win_l) + (SB + 3)'(fsel_l);
    assign lsum_r = (SB + 3)'(r_win_r) + (SB + 3)'(fsel_r);
    assign line_l = f_sat((SB + 6)'(lsum_l));
    assign line_r = f_sat((SB + 6)'(lsum_r));
    assign osum_l = (SB + 21)'(r_dry_l) + (SB + 21)'(r_wetp_l);
    assign osum_r = (SB + 21)'(r_dry_r) + (SB + 21)'(r_wetp_r);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xl  <= i_left_in;
            r_xr  <= i_right_in;
            r_ri  <= ri_new;
            r_f   <= f_new;
            r_hit <= (ri_new == r_w);
        end
        if (i_cmd.rd_b) begin
            r_a_l   <= rd_l;
            r_a_r   <= rd_r;
            r_dry_l <= dryp_l;
            r_dry_r <= dryp_r;
            r_win_l <= r_pp ? pl[SB+17:16] : (SB + 2)'(r_xl);
            r_win_r <= r_pp ? pr[SB+17:16] : (SB + 2)'(r_xr);
        end
        if (i_cmd.interp) begin
            r_prod_l <= prod_l;
            r_prod_r <= prod_r;
        end
        if (i_cmd.dly) begin
            r_d_l <= r_hit ? r_xl : isum_l[FRAC_W +: SB];
            r_d_r <= r_hit ? r_xr : isum_r[FRAC_W +: SB];
        end
        if (i_cmd.mul) begin
            r_fbt_l  <= fbp_l[SB+17:16];
            r_fbt_r  <= fbp_r[SB+17:16];
            r_wetp_l <= r_en ? wetp_l : '0;
            r_wetp_r <= r_en ? wetp_r : '0;
        end
        if (i_cmd.wb) begin
            r_out_l <= f_sat((SB + 6)'($signed(osum_l[SB+20:16])));
            r_out_r <= f_sat((SB + 6)'($signed(osum_r[SB+20:16])));
        end
    end

    assign we      = i_cmd.clr || (i_cmd.wb && !r_hit);
    assign wdata_l = i_cmd.clr ? '0 : line_l;
    assign wdata_r = i_cmd.clr ? '0 : line_r;

    sfdl_ram #(
        .WIDTH (SB),
        .DEPTH (LINE_DEPTH)
    ) u_left_line (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_w),
        .i_wdata (wdata_l),
        .i_raddr (raddr),
        .o_rdata (rd_l)
    );

    sfdl_ram #(
        .WIDTH (SB),
        .DEPTH (LINE_DEPTH)
    ) u_right_line (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_w),
        .i_wdata (wdata_r),
        .i_raddr (raddr),
        .o_rdata (rd_r)
    );

    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;

    `SFDL_ASSERT_NOW(a_raddr_in_range, i_clk, i_rst_n, i_cmd.load || i_cmd.rd_b,
                     raddr <= LAST_IDX)
    `SFDL_ASSERT_NOW(a_no_load_while_reducing, i_clk, i_rst_n, i_cmd.load, r_mcnt == '0)
    `SFDL_ASSERT_NOW(a_write_in_range, i_clk, i_rst_n, we, r_w <= LAST_IDX)

endmodule

@@ design/stereo_feedback_delay_line.sv @@
// Stereo feedback delay line with fractional delay, linear interpolation and ping-pong mode.
// Input stream: one stereo pair per transfer (left in the low half of tdata, right above).
// Output stream: one mixed stereo pair per accepted input, same packing, saturated.
// Configuration: write enable, register index and data; a register is written on any
// clock edge with i_cfg_we high. Write a register only while no item is in flight; the
// block itself does not enforce this. An input transfer loads the item, then the sequencer
// steps through second line read, interpolation, delay select, multiply and write-back,
// where the result is registered. The block handles one item at a time and takes no new
// input before that write-back; the two reads of each single-read-port line memory and
// the multiply stages set this. A result that waits for the receiver does not stop the
// next input transfer; the sequencer only stalls at its write-back step while the output
// register is still full. Reset: the sequencer first clears both line memories, one entry
// per cycle; no input is taken meanwhile. Writing delay_q8 starts a reduction of the delay
// modulo the line length, one quotient bit per cycle, during which input is held off too.
// Depends on sfdl_pkg, sfdl_ctrl, sfdl_dp and sfdl_ram.
module stereo_feedback_delay_line #(
    parameter int LINE_DEPTH  = 262144,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,   // left_in, right_in
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        m_axis_tdata,   // left_out, right_out
    input  logic                                      i_cfg_we,
    input  logic [sfdl_pkg::CFG_IDX_W-1:0]            i_cfg_idx,
    input  logic [sfdl_pkg::CFG_DATA_W-1:0]           i_cfg_data
);
    import sfdl_pkg::*;

    localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    t_cmd    cmd;
    t_status status;
    logic signed [SAMPLE_BITS-1:0] out_l, out_r;

    sfdl_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (cmd),
        .i_status  (status)
    );

    sfdl_dp #(
        .LINE_DEPTH  (LINE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_left_in   (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_right_in  (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .o_left_out  (out_l),
        .o_right_out (out_r)
    );

    assign m_axis_tdata = TDATA_W'({out_r, out_l});

endmodule
